### design/mbsg_pkg.sv
// Package for the multiband split gain block: widths, reset values,
// register indexes, band step struct and state encoding.
// No dependencies.
`default_nettype none

package mbsg_pkg;

	localparam int LP_COUNT   = 5;
	localparam int BAND_COUNT = 6;
	localparam int CHAN_W     = 3;
	localparam int SAMPLE_W   = 16;
	localparam int STATE_W    = 24;
	localparam int FRAC_SHIFT = STATE_W - SAMPLE_W;
	localparam int COEF_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int DIFF_W     = STATE_W + 1;
	localparam int BAND_W     = STATE_W + 1;
	localparam int PROD_W     = DIFF_W + COEF_W + 1;
	localparam int WPROD_W    = BAND_W + GAIN_W + 1;
	localparam int ACC_W      = 44;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int COEF_LO_W  = 3 * COEF_W;
	localparam int COEF_HI_W  = 2 * COEF_W;

	localparam logic [GAIN_W-1:0]    GAIN_RESET    = 16'd32768;
	localparam logic [COEF_LO_W-1:0] COEF_LO_RESET = 48'd246943247367170;
	localparam logic [COEF_HI_W-1:0] COEF_HI_RESET = 32'd1834266995;

	typedef logic [2:0] band_idx_t;
	localparam band_idx_t BAND_FIRST = 3'd0;
	localparam band_idx_t BAND_TOP   = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_ZERO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_ONE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_TWO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_THREE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_FOUR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_TOP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH  = 3'd7;

	typedef logic [LP_COUNT-1:0][STATE_W-1:0]  row_t;
	typedef logic [LP_COUNT-1:0][COEF_W-1:0]   coef_vec_t;
	typedef logic [BAND_COUNT-1:0][GAIN_W-1:0] gain_vec_t;

	typedef struct packed {
		logic      valid;
		band_idx_t band;
	} step_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} fsm_t;

endpackage

`default_nettype wire

### design/mbsg_ifs.sv
// Channel interfaces: sample input, result output and register write port.
// Depends on mbsg_pkg.
`default_nettype none

interface mbsg_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [mbsg_pkg::CHAN_W-1:0]          chan;
	logic signed [mbsg_pkg::SAMPLE_W-1:0] sample_in;
	logic                                 block_end_in;

	modport source (output valid, chan, sample_in, block_end_in, input ready);
	modport sink (input valid, chan, sample_in, block_end_in, output ready);
endinterface

interface mbsg_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [mbsg_pkg::CHAN_W-1:0]          chan_out;
	logic signed [mbsg_pkg::SAMPLE_W-1:0] sample_out;
	logic                                 block_end_out;
	logic                                 saturated;

	modport source (output valid, chan_out, sample_out, block_end_out, saturated,
		input ready);
	modport sink (input valid, chan_out, sample_out, block_end_out, saturated,
		output ready);
endinterface

interface mbsg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mbsg_pkg::CFG_IDX_W-1:0]    index;
	logic [mbsg_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/multiband_split_gain_core.sv
// One item at a time: an item is accepted only in idle, then a per-channel row read,
// six band steps through the shared filter multiplier and gain MAC pipeline, then
// the result is loaded into the output register together with the row write-back.
// A stalled output holds the next item in the core until the output register frees.
// Reset: gains to unity, coefficients to defaults, all filter rows read as zero
// through per-channel valid flags (no clearing pass).
`default_nettype none

module multiband_split_gain_core #(
	parameter int CHANNELS = 8
) (
	input logic         clk,
	input logic         arst_n,
	mbsg_in_if.sink     samples,
	mbsg_out_if.source  result,
	mbsg_cfg_if.sink    cfg
);
	import mbsg_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	gain_vec_t               gain_q;
	logic [COEF_LO_W-1:0]    coef_lo_q;
	logic [COEF_HI_W-1:0]    coef_hi_q;
	coef_vec_t               coefs;

	fsm_t                    state_q, state_d;
	band_idx_t               cnt_q;
	logic [CHAN_W-1:0]       chan_q;
	logic                    be_q;
	logic                    range_q;
	logic signed [STATE_W-1:0] x23_q;

	logic                    in_ready;
	logic                    accept;
	logic                    in_range;
	logic                    load;
	logic                    out_free;
	step_t                   issue;

	row_t                    z_row;
	row_t                    lp_row;
	step_t                   band_step;
	logic signed [BAND_W-1:0] band;
	logic                    done;
	logic signed [SAMPLE_W-1:0] mix_sample;
	logic                    mix_sat;

	logic                    out_valid_q;
	logic [CHAN_W-1:0]       chan_out_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                    be_out_q;
	logic                    sat_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BAND_COUNT; i++)
				gain_q[i] <= GAIN_RESET;
			coef_lo_q <= COEF_LO_RESET;
			coef_hi_q <= COEF_HI_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index) inside
				REG_GAIN_ZERO, REG_GAIN_ONE, REG_GAIN_TWO,
				REG_GAIN_THREE, REG_GAIN_FOUR, REG_GAIN_TOP:
					gain_q[cfg.index] <= cfg.data[GAIN_W-1:0];
				REG_COEF_LOW:  coef_lo_q <= cfg.data[COEF_LO_W-1:0];
				REG_COEF_HIGH: coef_hi_q <= cfg.data[COEF_HI_W-1:0];
				default: ;
			endcase
		end
	end

	assign coefs = coef_vec_t'({coef_hi_q, coef_lo_q});

	// sequencer
	assign accept   = samples.valid && in_ready;
	assign in_range = 32'(samples.chan) < CHANNELS;
	assign out_free = !out_valid_q || result.ready;
	assign samples.ready = in_ready;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load     = 1'b0;
		issue    = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (samples.valid)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				issue.valid = 1'b1;
				issue.band  = cnt_q;
				if (cnt_q == BAND_TOP)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (done) begin
					if (out_free) begin
						load    = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= BAND_FIRST;
		end else begin
			state_q <= state_d;
			if (accept)
				cnt_q <= BAND_FIRST;
			else if (state_q == ST_RUN)
				cnt_q <= cnt_q + band_idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q  <= samples.chan;
			be_q    <= samples.block_end_in;
			range_q <= in_range;
			x23_q   <= $signed({samples.sample_in, {FRAC_SHIFT{1'b0}}});
		end
	end

	mbsg_row_mem #(
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_hit  (in_range),
		.rd_addr (AW'(samples.chan)),
		.rd_row  (z_row),
		.wr_en   (load && range_q),
		.wr_addr (AW'(chan_q)),
		.wr_row  (lp_row)
	);

	mbsg_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.x23       (x23_q),
		.z_row     (z_row),
		.coefs     (coefs),
		.lp_row    (lp_row),
		.band_step (band_step),
		.band      (band)
	);

	mbsg_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.band_step (band_step),
		.band      (band),
		.gains     (gain_q),
		.done      (done),
		.sample    (mix_sample),
		.sat       (mix_sat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chan_out_q   <= chan_q;
			sample_out_q <= mix_sample;
			be_out_q     <= be_q;
			sat_q        <= mix_sat;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.chan_out      = chan_out_q;
	assign result.sample_out    = sample_out_q;
	assign result.block_end_out = be_out_q;
	assign result.saturated     = sat_q;

endmodule

`default_nettype wire

### design/mbsg_row_mem.sv
// Per-channel filter state memory: one row of five lowpass states per channel,
// registered read, with a valid flag per row so unwritten rows read as zero.
// Depends on mbsg_pkg.
`default_nettype none

module mbsg_row_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic             rd_hit,
	input  logic [AW-1:0]    rd_addr,
	output mbsg_pkg::row_t   rd_row,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  mbsg_pkg::row_t   wr_row
);
	import mbsg_pkg::*;

	row_t             mem [DEPTH];
	row_t             rd_q;
	logic             hit_q;
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_row;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				hit_q <= rd_hit && vld_q[rd_addr];
		end
	end

	// out-of-range channel or never-written row starts from zero
	assign rd_row = hit_q ? rd_q : '0;

endmodule

`default_nettype wire

### design/mbsg_filter.sv
// Shared one-pole lowpass unit: one filter per step, coefficient multiply in
// the first stage, rounding and band difference in the second.
// Depends on mbsg_pkg.
`default_nettype none

module mbsg_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mbsg_pkg::step_t                      issue,
	input  logic signed [mbsg_pkg::STATE_W-1:0]  x23,
	input  mbsg_pkg::row_t                       z_row,
	input  mbsg_pkg::coef_vec_t                  coefs,
	output mbsg_pkg::row_t                       lp_row,
	output mbsg_pkg::step_t                      band_step,
	output logic signed [mbsg_pkg::BAND_W-1:0]   band
);
	import mbsg_pkg::*;

	localparam int LPF_W = PROD_W - COEF_W + 1;
	localparam logic signed [LPF_W-1:0] LP_MAX = LPF_W'(2 ** (STATE_W - 1) - 1);
	localparam logic signed [LPF_W-1:0] LP_MIN = -LP_MAX - LPF_W'(1);
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(2 ** (COEF_W - 1));

	logic [COEF_W-1:0]          c_sel;
	logic signed [STATE_W-1:0]  z_sel;
	logic signed [DIFF_W-1:0]   diff;

	step_t                      step_s1;
	logic signed [PROD_W-1:0]   prod_s1;

	logic signed [PROD_W-1:0]   rnd;
	logic signed [LPF_W-2:0]    quo;
	logic signed [LPF_W-1:0]    lp_full;
	logic signed [STATE_W-1:0]  lp_sat;
	logic signed [STATE_W-1:0]  low;
	logic signed [BAND_W-1:0]   band_d;

	step_t                      step_s2;
	logic signed [BAND_W-1:0]   band_s2;
	logic signed [STATE_W-1:0]  lower_q;
	row_t                       lp_row_q;

	// stage 1: c * (z - x)
	always_comb begin
		c_sel = '0;
		z_sel = '0;
		if (issue.band < BAND_TOP) begin
			c_sel = coefs[issue.band];
			z_sel = z_row[issue.band];
		end
		diff = DIFF_W'(z_sel) - DIFF_W'(x23);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_s1 <= '0;
		else
			step_s1 <= issue;
	end

	always_ff @(posedge clk)
		prod_s1 <= PROD_W'($signed({1'b0, c_sel}) * diff);

	// stage 2: round half up, new state, band difference
	always_comb begin
		rnd     = prod_s1 + RND_HALF;
		quo     = rnd[PROD_W-1:COEF_W];
		lp_full = LPF_W'(x23) + LPF_W'(quo);
		if (lp_full > LP_MAX)
			lp_sat = LP_MAX[STATE_W-1:0];
		else if (lp_full < LP_MIN)
			lp_sat = LP_MIN[STATE_W-1:0];
		else
			lp_sat = lp_full[STATE_W-1:0];
		low = (step_s1.band == BAND_FIRST) ? '0 : lower_q;
		if (step_s1.band == BAND_TOP)
			band_d = BAND_W'(x23) - BAND_W'(low);
		else
			band_d = BAND_W'(lp_sat) - BAND_W'(low);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_s2 <= '0;
		else
			step_s2 <= step_s1;
	end

	always_ff @(posedge clk) begin
		band_s2 <= band_d;
		if (step_s1.valid && step_s1.band < BAND_TOP) begin
			lp_row_q[step_s1.band] <= lp_sat;
			lower_q                <= lp_sat;
		end
	end

	assign lp_row    = lp_row_q;
	assign band_step = step_s2;
	assign band      = band_s2;

endmodule

`default_nettype wire

### design/mbsg_mix.sv
// Band gain multiply-accumulate and final round/saturate to Q1.15.
// Depends on mbsg_pkg.
`default_nettype none

module mbsg_mix (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mbsg_pkg::step_t                      band_step,
	input  logic signed [mbsg_pkg::BAND_W-1:0]   band,
	input  mbsg_pkg::gain_vec_t                  gains,
	output logic                                 done,
	output logic signed [mbsg_pkg::SAMPLE_W-1:0] sample,
	output logic                                 sat
);
	import mbsg_pkg::*;

	localparam int SHIFT = STATE_W - 1;
	localparam int Y_W   = ACC_W - SHIFT;
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (SHIFT - 1));
	localparam logic signed [Y_W-1:0]   Y_MAX    = Y_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [Y_W-1:0]   Y_MIN    = -Y_MAX - Y_W'(1);

	step_t                     step_s3;
	logic signed [WPROD_W-1:0] wprod_s3;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      done_q;
	logic signed [ACC_W-1:0]   sum;
	logic signed [Y_W-1:0]     y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_s3 <= '0;
		else
			step_s3 <= band_step;
	end

	always_ff @(posedge clk)
		wprod_s3 <= WPROD_W'(band * $signed({1'b0, gains[band_step.band]}));

	always_ff @(posedge clk) begin
		if (step_s3.valid)
			acc_q <= ((step_s3.band == BAND_FIRST) ? '0 : acc_q) + ACC_W'(wprod_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= step_s3.valid && (step_s3.band == BAND_TOP);
	end

	// round half up, then clamp
	always_comb begin
		sum = acc_q + RND_HALF;
		y   = sum[ACC_W-1:SHIFT];
		sat = 1'b0;
		if (y > Y_MAX) begin
			sample = Y_MAX[SAMPLE_W-1:0];
			sat    = 1'b1;
		end else if (y < Y_MIN) begin
			sample = Y_MIN[SAMPLE_W-1:0];
			sat    = 1'b1;
		end else begin
			sample = y[SAMPLE_W-1:0];
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

### design/mbsg_checker.sv
// Port-level checks for the multiband split gain core, bound to the top level.
// Depends on mbsg_pkg and the channel interfaces.
`default_nettype none

module mbsg_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic [mbsg_pkg::CHAN_W-1:0]          in_chan,
	input logic                                 in_be,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [mbsg_pkg::CHAN_W-1:0]          out_chan,
	input logic signed [mbsg_pkg::SAMPLE_W-1:0] out_sample,
	input logic                                 out_be,
	input logic                                 out_sat
);
	import mbsg_pkg::*;

	logic [CHAN_W-1:0] last_chan_q;
	logic              last_be_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_chan_q <= '0;
			last_be_q   <= 1'b0;
		end else if (in_valid && in_ready) begin
			last_chan_q <= in_chan;
			last_be_q   <= in_be;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item in flight");

	a_tags_follow: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (out_chan == last_chan_q) && (out_be == last_be_q))
		else $error("result tags do not match accepted item");

	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sat |-> (out_sample == 16'sh7fff) || (out_sample == 16'sh8000))
		else $error("saturated flag without clipped sample");

endmodule

bind multiband_split_gain_core mbsg_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.in_chan    (samples.chan),
	.in_be      (samples.block_end_in),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_chan   (result.chan_out),
	.out_sample (result.sample_out),
	.out_be     (result.block_end_out),
	.out_sat    (result.saturated)
);

`default_nettype wire

### bench/tb_multiband_split_gain_core.sv
// Testbench for multiband_split_gain_core: feeds audio samples through the
// band-split gain core under random idling and compares each result with a predictor.
// Depends on mbsg_pkg, mbsg_ifs.sv and the core itself.
`timescale 1ns / 100ps

module tb_multiband_split_gain_core;
	import mbsg_pkg::*;

	localparam int N_CHAN         = 8;
	localparam int RANDOM_ITEMS   = 166;
	localparam int PHASE_COUNT    = 8;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_PAD      = 30;

	typedef struct packed {
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_end;
	} sample_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_end;
		logic                       saturated;
	} band_sum_t;

	typedef enum int {
		PROF_DEFAULT,
		PROF_RANDOM_COEFS,
		PROF_CUT,
		PROF_WIDE,
		PROF_EXTREME
	} profile_t;

	localparam logic [CFG_IDX_W-1:0] GAIN_REGS [BAND_COUNT] = '{
		REG_GAIN_ZERO, REG_GAIN_ONE, REG_GAIN_TWO,
		REG_GAIN_THREE, REG_GAIN_FOUR, REG_GAIN_TOP
	};

	logic clk;
	logic arst_n;

	mbsg_in_if  samples_if ();
	mbsg_out_if result_if ();
	mbsg_cfg_if cfg_if ();

	multiband_split_gain_core #(
		.CHANNELS(N_CHAN)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// predictor copy of the block's registers and filter rows
	logic [GAIN_W-1:0]          gain_set [BAND_COUNT];
	logic [COEF_LO_W-1:0]       coef_lo;
	logic [COEF_HI_W-1:0]       coef_hi;
	logic signed [STATE_W-1:0]  lp_state [N_CHAN][LP_COUNT];

	sample_item_t sample_backlog[$];
	band_sum_t    expected_results[$];

	sample_item_t next_item;
	band_sum_t    oldest_result;
	int unsigned  send_gap = 0;
	int unsigned  stall_left = 0;
	int unsigned  hold_left = 0;
	int unsigned  hold_req = 0;
	int unsigned  hold_ack = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  mismatch_count = 0;
	bit           no_idle = 1'b0;

	function automatic band_sum_t split_and_weigh(input sample_item_t it);
		band_sum_t r;
		longint x23, z, c, lp, lower, acc, y;
		bit in_range;
		int k;
		x23 = longint'(it.sample) * 256;
		in_range = int'(it.chan) < N_CHAN;
		lower = 0;
		acc = 0;
		for (k = 0; k < LP_COUNT; k++) begin
			z = in_range ? longint'(lp_state[it.chan][k]) : 0;
			c = (k < 3) ? longint'(coef_lo[COEF_W*k +: COEF_W])
				: longint'(coef_hi[COEF_W*(k-3) +: COEF_W]);
			lp = x23 + ((c * (z - x23) + 32768) >>> 16);
			if (lp > 8388607)
				lp = 8388607;
			if (lp < -8388608)
				lp = -8388608;
			if (in_range)
				lp_state[it.chan][k] = lp[STATE_W-1:0];
			acc += (lp - lower) * longint'(gain_set[k]);
			lower = lp;
		end
		acc += (x23 - lower) * longint'(gain_set[BAND_TOP]);
		y = (acc + 4194304) >>> 23;
		r.saturated = 1'b0;
		if (y > 32767) begin
			y = 32767;
			r.saturated = 1'b1;
		end else if (y < -32768) begin
			y = -32768;
			r.saturated = 1'b1;
		end
		r.chan = it.chan;
		r.sample = y[SAMPLE_W-1:0];
		r.block_end = it.block_end;
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 14);
		return $urandom_range(20, 80);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
			samples_if.chan <= '0;
			samples_if.sample_in <= '0;
			samples_if.block_end_in <= 1'b0;
			send_gap <= 0;
		end else begin
			if (samples_if.valid && samples_if.ready)
				expected_results.push_back(split_and_weigh(sample_item_t'{
					samples_if.chan, samples_if.sample_in, samples_if.block_end_in}));
			if (!samples_if.valid || samples_if.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					samples_if.valid <= 1'b0;
				end else if (sample_backlog.size() != 0) begin
					next_item = sample_backlog.pop_front();
					samples_if.chan <= next_item.chan;
					samples_if.sample_in <= next_item.sample;
					samples_if.block_end_in <= next_item.block_end;
					samples_if.valid <= 1'b1;
					send_gap <= pick_idle();
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: chan_out=%0d sample_out=%0d",
						result_if.chan_out, result_if.sample_out);
					mismatch_count++;
				end else begin
					oldest_result = expected_results.pop_front();
					if (result_if.chan_out !== oldest_result.chan) begin
						$error("chan_out: expected %0d, got %0d",
							oldest_result.chan, result_if.chan_out);
						mismatch_count++;
					end
					if (result_if.sample_out !== oldest_result.sample) begin
						$error("sample_out: expected %0d, got %0d",
							oldest_result.sample, result_if.sample_out);
						mismatch_count++;
					end
					if (result_if.block_end_out !== oldest_result.block_end) begin
						$error("block_end_out: expected %0b, got %0b",
							oldest_result.block_end, result_if.block_end_out);
						mismatch_count++;
					end
					if (result_if.saturated !== oldest_result.saturated) begin
						$error("saturated: expected %0b, got %0b",
							oldest_result.saturated, result_if.saturated);
						mismatch_count++;
					end
				end
			end
			if (hold_ack != hold_req) begin
				hold_ack <= hold_req;
				hold_left <= LONG_HOLD;
				result_if.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_if.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				stall_left <= pick_idle();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples_if.valid && samples_if.ready) ||
				(result_if.valid && result_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_multiband_split_gain_core failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// bits above the register's width are ignored by the block; fill them at random
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		logic [63:0] junk;
		int w;
		case (idx)
			REG_COEF_LOW:  w = COEF_LO_W;
			REG_COEF_HIGH: w = COEF_HI_W;
			default:       w = GAIN_W;
		endcase
		junk = $urandom_range(0, 1) ? ({$urandom, $urandom} << w) : 64'd0;
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= CFG_DATA_W'(junk | 64'(val));
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_COEF_LOW:  coef_lo = val[COEF_LO_W-1:0];
			REG_COEF_HIGH: coef_hi = val[COEF_HI_W-1:0];
			default:       gain_set[idx] = val[GAIN_W-1:0];
		endcase
	endtask

	task automatic write_gains(input logic [GAIN_W-1:0] g);
		int i;
		for (i = 0; i < BAND_COUNT; i++)
			write_reg(GAIN_REGS[i], CFG_DATA_W'(g));
	endtask

	function automatic logic [COEF_W-1:0] pick_coef(input profile_t kind);
		if (kind == PROF_EXTREME)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic load_profile(input profile_t kind);
		int i;
		logic [GAIN_W-1:0] g;
		for (i = 0; i < BAND_COUNT; i++) begin
			case (kind)
				PROF_DEFAULT, PROF_RANDOM_COEFS: g = GAIN_RESET;
				PROF_CUT:  g = 16'($urandom_range(0, 32768));
				PROF_WIDE: g = 16'($urandom_range(0, 65535));
				default:   g = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			endcase
			write_reg(GAIN_REGS[i], CFG_DATA_W'(g));
		end
		if (kind == PROF_DEFAULT || kind == PROF_CUT) begin
			write_reg(REG_COEF_LOW, COEF_LO_RESET);
			write_reg(REG_COEF_HIGH, CFG_DATA_W'(COEF_HI_RESET));
		end else begin
			write_reg(REG_COEF_LOW, {pick_coef(kind), pick_coef(kind), pick_coef(kind)});
			write_reg(REG_COEF_HIGH, CFG_DATA_W'({pick_coef(kind), pick_coef(kind)}));
		end
	endtask

	task automatic push_item(input logic [CHAN_W-1:0] chan, input int sample, input logic be);
		sample_backlog.push_back(sample_item_t'{chan, SAMPLE_W'(sample), be});
	endtask

	// bursts per channel: random audio, held extremes (drives filters to the
	// rails), quiet signal, and full-scale alternation
	task automatic queue_bursts(input int unsigned n);
		int unsigned made, len, j, mode;
		logic [CHAN_W-1:0] ch;
		logic signed [SAMPLE_W-1:0] s, rail;
		logic be;
		made = 0;
		while (made < n) begin
			ch = CHAN_W'($urandom_range(0, N_CHAN - 1));
			len = $urandom_range(1, 12);
			mode = $urandom_range(0, 3);
			rail = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			for (j = 0; j < len && made < n; j++) begin
				case (mode)
					0: s = 16'($urandom_range(0, 65535));
					1: s = rail;
					2: s = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
					default: s = j[0] ? 16'sh7FFF : 16'sh8000;
				endcase
				be = (j == len - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
				sample_backlog.push_back(sample_item_t'{ch, s, be});
				made++;
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_backlog.size() != 0 || samples_if.valid || expected_results.size() != 0);
	endtask

	initial begin
		profile_t phase_kind [PHASE_COUNT];
		int ph, ch, k;
		phase_kind = '{PROF_DEFAULT, PROF_CUT, PROF_RANDOM_COEFS, PROF_WIDE,
			PROF_EXTREME, PROF_CUT, PROF_WIDE, PROF_DEFAULT};
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.chan = '0;
		samples_if.sample_in = '0;
		samples_if.block_end_in = 1'b0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		for (k = 0; k < BAND_COUNT; k++)
			gain_set[k] = GAIN_RESET;
		coef_lo = COEF_LO_RESET;
		coef_hi = COEF_HI_RESET;
		for (ch = 0; ch < N_CHAN; ch++)
			for (k = 0; k < LP_COUNT; k++)
				lp_state[ch][k] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: unity gains, so bands must sum back to the input
		push_item(0, 32767, 1'b0);
		push_item(0, -32768, 1'b1);
		push_item(1, 0, 1'b0);
		push_item(1, -1, 1'b0);
		push_item(2, 1, 1'b1);
		push_item(7, 32767, 1'b0);
		push_item(7, -32768, 1'b1);
		for (k = 0; k < 3; k++)
			push_item(3, 32767, 1'b0);
		push_item(3, -32768, 1'b0);
		push_item(3, -32768, 1'b1);
		wait_drained();

		// maximum boost clips both ways; slowest and fastest poles
		write_gains(16'hFFFF);
		write_reg(REG_COEF_LOW, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_COEF_HIGH, 48'h0000_0000_0000);
		push_item(4, 32767, 1'b0);
		push_item(4, -32768, 1'b1);
		push_item(5, 16000, 1'b0);
		push_item(5, -16000, 1'b0);
		wait_drained();

		// all bands muted
		write_gains(16'h0000);
		push_item(6, 32767, 1'b1);
		push_item(6, -32768, 1'b0);
		wait_drained();

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			load_profile(phase_kind[ph]);
			no_idle = (ph == 4);
			queue_bursts(RANDOM_ITEMS);
			// receiver holds off while the backlog keeps the input busy
			if (ph == 1)
				hold_req++;
			wait_drained();
		end
		no_idle = 1'b0;

		repeat (DRAIN_PAD) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_multiband_split_gain_core passed");
		else
			$display("tb_multiband_split_gain_core failed");
		$finish;
	end

endmodule
